// ===== design/cfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and codes of the contiguous fit allocator
// Request and result beat layouts, status and mode codes, register indexes
// and the sequencer state type.
// ----------------------------------------------------------------------------
package cfa_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_LIMIT = 1'b1;

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_NEXT  = 2'd1;
	localparam logic [1:0] MODE_BEST  = 2'd2;
	localparam logic [1:0] MODE_WORST = 2'd3;

	localparam logic [1:0] STAT_PLACED  = 2'd0;
	localparam logic [1:0] STAT_EVICTED = 2'd1;
	localparam logic [1:0] STAT_REJECT  = 2'd2;

	localparam logic [1:0] FIT_MODE_RST   = MODE_FIRST;
	localparam logic [2:0] SWAP_LIMIT_RST = 3'd3;
	localparam logic [2:0] SWAP_MAX       = 3'd7;

	typedef struct packed {
		logic [7:0] proc_id;
		logic [7:0] proc_size;
		logic [2:0] swap_count;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] start_unit;
		logic [7:0] evicted_id;
		logic [2:0] evicted_swaps;
		logic       evicted_requeue;
		logic [7:0] resident_count;
		logic [6:0] hole_count;
		logic [7:0] used_units;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_TAIL,
		ST_RD_HEAD,
		ST_SCAN,
		ST_DECIDE,
		ST_MARK,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== design/contiguous_fit_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_fit_allocator: first, next, best or worst fit over a unit map
// Places variable-size requests into free runs of a one-bit occupancy map
// and evicts the oldest resident when nothing fits.
// ----------------------------------------------------------------------------
// Usage. A request beat (req) is taken on a rising edge with start high and
// busy low. Busy then stays high while the sequencer works the request. The
// single result beat appears on res with result_valid high for exactly one
// cycle; the receiver cannot hold it off, so it must sample it then.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while busy is low and no result is pending.
// Sequence. A rejected size answers in the cycle after acceptance. Otherwise
// the block reads two resident queue entries, streams the occupancy memory
// through one compare unit at one unit per cycle, decides, then marks or
// frees the placed or evicted run one unit per cycle before the result beat.
// Requests run one at a time; the occupancy memory has a single read port
// and the scan has a single comparator.
// Reset. After arst_n releases, a clearing pass zeroes the occupancy memory
// with busy high; configuration writes are still taken.
// Hole and used counts are tracked incrementally from each map change.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator
	import cfa_pkg::*;
#(
	parameter int MEM_UNITS = 128
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  req_t                   req,
	output logic                   result_valid,
	output res_t                   res,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CFG_IDX_W-1:0]   cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data
);

	// Address width of a unit and count width able to hold MEM_UNITS itself.
	localparam int AW = $clog2(MEM_UNITS);
	localparam int CW = $clog2(MEM_UNITS + 1);
	// Resident queue entry: id, start, size, swap count.
	localparam int EW = 8 + AW + CW + 3;

	localparam logic [AW-1:0] LAST_UNIT = AW'(MEM_UNITS - 1);
	localparam logic [CW-1:0] UNITS_C   = CW'(MEM_UNITS);

	state_t state_q, state_d;

	// Configuration registers.
	logic [1:0] fit_mode_q;
	logic [2:0] swap_limit_q;

	// Occupancy memory, one read and one write port, read data registered.
	logic           occ_mem [MEM_UNITS];
	logic           occ_we;
	logic [AW-1:0]  occ_waddr;
	logic           occ_wdata;
	logic [AW-1:0]  occ_raddr;
	logic           occ_rdata_s1;

	// Resident queue memory.
	logic [EW-1:0]  fifo_mem [MEM_UNITS];
	logic           fifo_we;
	logic [AW-1:0]  fifo_raddr;
	logic [EW-1:0]  fifo_rdata_q;
	logic [AW-1:0]  head_q, tail_q;
	logic [CW-1:0]  fill_q;

	// Request held for the duration of the work.
	logic [7:0]     id_q;
	logic [CW-1:0]  size_q;
	logic [2:0]     swaps_q;

	// Entries read before the scan.
	logic [AW-1:0]  origin_q;
	logic [7:0]     hd_id_q;
	logic [AW-1:0]  hd_start_q;
	logic [CW-1:0]  hd_size_q;
	logic [2:0]     hd_swaps_q;

	// Scan pipeline.
	logic [CW-1:0]  scan_a_q;
	logic           vld_s1;
	logic [AW-1:0]  p_s1;
	logic           in_run_q;
	logic [AW-1:0]  run_start_q;
	logic [CW-1:0]  run_len_q;

	// Selection state.
	logic           found_q, fa_q, fb_q;
	logic [AW-1:0]  pick_q, after_q, before_q;
	logic [CW-1:0]  pick_len_q, after_len_q, before_len_q;
	logic           left_free_q, right_free_q;

	// Mark sweep.
	logic [AW-1:0]  mk_idx_q;
	logic [CW-1:0]  mk_left_q;
	logic           mk_val_q;
	logic [AW-1:0]  clr_idx_q;

	// Tracked map statistics.
	logic [CW-1:0]  hole_q, used_q;

	// Result fields held for the result beat.
	logic [1:0]     r_status_q;
	logic [AW-1:0]  r_start_q;
	logic [7:0]     r_ev_id_q;
	logic [2:0]     r_ev_swaps_q;
	logic           r_ev_req_q;

	// Request size check, done in a width wide enough for either operand.
	logic [CW+7:0]  size_wide;
	logic           size_ok;
	assign size_wide = {{CW{1'b0}}, req.proc_size};
	assign size_ok   = (req.proc_size != 8'd0) && (size_wide <= (CW+8)'(MEM_UNITS));

	logic accept;
	assign accept = start && (state_q == ST_IDLE);

	// Pointer helpers.
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == LAST_UNIT) ? '0 : p + AW'(1);
	endfunction

	logic [AW-1:0] tail_prev;
	assign tail_prev = (tail_q == '0) ? LAST_UNIT : tail_q - AW'(1);

	// Start and size of the registered queue read.
	logic [AW-1:0]  fr_start;
	logic [CW-1:0]  fr_size;
	assign fr_start = fifo_rdata_q[AW+CW+2:CW+3];
	assign fr_size  = fifo_rdata_q[CW+2:3];

	logic [CW:0] tail_end;
	assign tail_end = {1'b0, {(CW-AW){1'b0}}, fr_start} + {1'b0, fr_size};

	// Run close detection on the bit now out of the memory.
	logic           bit_free, last_p;
	logic [AW-1:0]  nstart;
	logic [CW-1:0]  nlen;
	logic           close_ev;
	logic [AW-1:0]  cs;
	logic [CW-1:0]  cl;
	logic           fits;
	assign bit_free = !occ_rdata_s1;
	assign last_p   = (p_s1 == LAST_UNIT);
	assign nstart   = in_run_q ? run_start_q : p_s1;
	assign nlen     = in_run_q ? run_len_q + CW'(1) : CW'(1);
	always_comb begin
		close_ev = 1'b0;
		cs = run_start_q;
		cl = run_len_q;
		if (vld_s1) begin
			if (!bit_free && in_run_q) begin
				close_ev = 1'b1;
			end else if (bit_free && last_p) begin
				close_ev = 1'b1;
				cs = nstart;
				cl = nlen;
			end
		end
	end
	assign fits = (cl >= size_q);

	// Neighbor positions of the head resident, used to update the hole count.
	logic [CW:0] hd_end;
	logic        at_left, at_right;
	assign hd_end   = {1'b0, {(CW-AW){1'b0}}, hd_start_q} + {1'b0, hd_size_q};
	assign at_left  = (hd_start_q != '0) && (p_s1 == hd_start_q - AW'(1));
	assign at_right = ({1'b0, {(CW-AW){1'b0}}, p_s1} == hd_end);

	// Final choice.
	logic           ch_found;
	logic [AW-1:0]  ch_start;
	logic [CW-1:0]  ch_len;
	always_comb begin
		ch_found = found_q;
		ch_start = pick_q;
		ch_len   = pick_len_q;
		case (fit_mode_q)
			MODE_NEXT: begin
				ch_found = fa_q || fb_q;
				ch_start = fa_q ? after_q : before_q;
				ch_len   = fa_q ? after_len_q : before_len_q;
			end
			MODE_WORST: begin
				ch_found = (pick_len_q >= size_q);
			end
			default: begin
			end
		endcase
	end

	logic do_place, do_evict;
	assign do_place = ch_found && (fill_q < UNITS_C);
	assign do_evict = !ch_found && (fill_q != '0);

	logic [2:0] ev_sw;
	assign ev_sw = (hd_swaps_q >= SWAP_MAX) ? SWAP_MAX : hd_swaps_q + 3'd1;

	logic [CW:0] holes_freed;
	assign holes_freed = {1'b0, hole_q} + (CW+1)'(1)
		- (CW+1)'(left_free_q) - (CW+1)'(right_free_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (clr_idx_q == LAST_UNIT) state_d = ST_IDLE;
			ST_IDLE:    if (start) state_d = size_ok ? ST_RD_TAIL : ST_DONE;
			ST_RD_TAIL: state_d = ST_RD_HEAD;
			ST_RD_HEAD: state_d = ST_SCAN;
			ST_SCAN:    if (vld_s1 && last_p) state_d = ST_DECIDE;
			ST_DECIDE:  state_d = (do_place || do_evict) ? ST_MARK : ST_DONE;
			ST_MARK:    if (mk_left_q == CW'(1)) state_d = ST_DONE;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs and memory controls.
	always_comb begin
		busy       = (state_q != ST_IDLE);
		result_valid = (state_q == ST_DONE);
		cfg_ready  = 1'b1;
		occ_we     = 1'b0;
		occ_waddr  = clr_idx_q;
		occ_wdata  = 1'b0;
		occ_raddr  = scan_a_q[AW-1:0];
		fifo_we    = 1'b0;
		fifo_raddr = head_q;
		case (state_q)
			ST_CLEAR: begin
				occ_we = 1'b1;
			end
			ST_IDLE: begin
				fifo_raddr = tail_prev;
			end
			ST_MARK: begin
				occ_we    = 1'b1;
				occ_waddr = mk_idx_q;
				occ_wdata = mk_val_q;
			end
			ST_DECIDE: begin
				fifo_we = do_place;
			end
			default: begin
			end
		endcase
	end

	logic [AW+7:0] start_pad;
	logic [CW+7:0] fill_pad, hole_pad, used_pad;
	assign start_pad = {8'd0, r_start_q};
	assign fill_pad  = {8'd0, fill_q};
	assign hole_pad  = {8'd0, hole_q};
	assign used_pad  = {8'd0, used_q};
	always_comb begin
		res.status          = r_status_q;
		res.start_unit      = start_pad[6:0];
		res.evicted_id      = r_ev_id_q;
		res.evicted_swaps   = r_ev_swaps_q;
		res.evicted_requeue = r_ev_req_q;
		res.resident_count  = fill_pad[7:0];
		res.hole_count      = hole_pad[6:0];
		res.used_units      = used_pad[7:0];
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_waddr] <= occ_wdata;
		end
		occ_rdata_s1 <= occ_mem[occ_raddr];
		if (fifo_we) begin
			fifo_mem[tail_q] <= {id_q, ch_start, size_q, swaps_q};
		end
		fifo_rdata_q <= fifo_mem[fifo_raddr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			fit_mode_q   <= FIT_MODE_RST;
			swap_limit_q <= SWAP_LIMIT_RST;
			clr_idx_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			hole_q       <= CW'(1);
			used_q       <= '0;
			vld_s1       <= 1'b0;
			scan_a_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_FIT_MODE:   fit_mode_q <= cfg_data[1:0];
					REG_SWAP_LIMIT: swap_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			vld_s1 <= (state_q == ST_SCAN) && (scan_a_q < UNITS_C);
			if (state_q == ST_RD_HEAD) begin
				scan_a_q <= '0;
			end else if (state_q == ST_SCAN && scan_a_q < UNITS_C) begin
				scan_a_q <= scan_a_q + CW'(1);
			end
			if (state_q == ST_DECIDE) begin
				if (do_place) begin
					tail_q <= ptr_inc(tail_q);
					fill_q <= fill_q + CW'(1);
					used_q <= used_q + size_q;
					if (ch_len == size_q) begin
						hole_q <= hole_q - CW'(1);
					end
				end else if (do_evict) begin
					head_q <= ptr_inc(head_q);
					fill_q <= fill_q - CW'(1);
					used_q <= used_q - hd_size_q;
					hole_q <= holes_freed[CW-1:0];
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		p_s1 <= scan_a_q[AW-1:0];
		if (accept) begin
			id_q         <= req.proc_id;
			size_q       <= size_wide[CW-1:0];
			swaps_q      <= req.swap_count;
			r_status_q   <= STAT_REJECT;
			r_start_q    <= '0;
			r_ev_id_q    <= '0;
			r_ev_swaps_q <= '0;
			r_ev_req_q   <= 1'b0;
		end
		if (state_q == ST_RD_TAIL) begin
			origin_q <= '0;
			if (fill_q != '0 && tail_end < (CW+1)'(MEM_UNITS)) begin
				origin_q <= tail_end[AW-1:0];
			end
		end
		if (state_q == ST_RD_HEAD) begin
			in_run_q     <= 1'b0;
			found_q      <= 1'b0;
			fa_q         <= 1'b0;
			fb_q         <= 1'b0;
			pick_q       <= '0;
			pick_len_q   <= '0;
			left_free_q  <= 1'b0;
			right_free_q <= 1'b0;
		end
		if (state_q == ST_SCAN && scan_a_q == '0) begin
			{hd_id_q, hd_start_q, hd_size_q, hd_swaps_q} <= fifo_rdata_q;
		end
		if (vld_s1) begin
			in_run_q    <= bit_free;
			run_start_q <= nstart;
			run_len_q   <= nlen;
			if (at_left) left_free_q <= bit_free;
			if (at_right) right_free_q <= bit_free;
			if (close_ev) begin
				case (fit_mode_q)
					MODE_FIRST: begin
						if (!found_q && fits) begin
							found_q    <= 1'b1;
							pick_q     <= cs;
							pick_len_q <= cl;
						end
					end
					MODE_NEXT: begin
						if (fits && cs >= origin_q && !fa_q) begin
							fa_q        <= 1'b1;
							after_q     <= cs;
							after_len_q <= cl;
						end
						if (fits && cs < origin_q && !fb_q) begin
							fb_q         <= 1'b1;
							before_q     <= cs;
							before_len_q <= cl;
						end
					end
					MODE_BEST: begin
						if (fits && (!found_q || cl < pick_len_q)) begin
							found_q    <= 1'b1;
							pick_q     <= cs;
							pick_len_q <= cl;
						end
					end
					default: begin
						if (cl > pick_len_q) begin
							pick_q     <= cs;
							pick_len_q <= cl;
						end
					end
				endcase
			end
		end
		if (state_q == ST_DECIDE) begin
			if (do_place) begin
				r_status_q <= STAT_PLACED;
				r_start_q  <= ch_start;
				mk_idx_q   <= ch_start;
				mk_left_q  <= size_q;
				mk_val_q   <= 1'b1;
			end else if (do_evict) begin
				r_status_q   <= STAT_EVICTED;
				r_ev_id_q    <= hd_id_q;
				r_ev_swaps_q <= ev_sw;
				r_ev_req_q   <= (ev_sw < swap_limit_q);
				mk_idx_q     <= hd_start_q;
				mk_left_q    <= hd_size_q;
				mk_val_q     <= 1'b0;
			end
		end
		if (state_q == ST_MARK) begin
			mk_idx_q  <= mk_idx_q + AW'(1);
			mk_left_q <= mk_left_q - CW'(1);
		end
	end

`ifndef SYNTHESIS
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held two cycles");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= UNITS_C)
		else $error("resident count beyond capacity");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accepting a request");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UNITS_C)
		else $error("used units beyond memory size");
	a_place_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && res.status == STAT_PLACED) |-> (fill_q != '0))
		else $error("placement left no resident");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the contiguous fit allocator
// Drives request beats in random bursts, mirrors the occupancy map and the
// resident queue in a behavioral allocator, and checks every result beat
// field by field against the oldest predicted reply.
// ----------------------------------------------------------------------------
module tb_top;
	import cfa_pkg::*;

	localparam int UNITS = 128;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	req_t                  req;
	logic                  result_valid;
	res_t                  res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	contiguous_fit_allocator #(.MEM_UNITS(UNITS)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result_valid (result_valid),
		.res          (res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Behavioral copy of the allocator state.
	bit        unit_busy [UNITS];
	bit [7:0]  fifo_id [UNITS];
	int        fifo_start [UNITS];
	int        fifo_len [UNITS];
	bit [2:0]  fifo_swaps [UNITS];
	int        q_head, q_tail, q_fill;
	bit [1:0]  cur_mode;
	bit [2:0]  cur_limit;

	res_t      expected_replies[$];
	req_t      requeue_list[$];
	bit        failed;
	int        burst_left;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	function automatic void mark_run(int first, int len, bit v);
		for (int u = first; u < first + len && u < UNITS; u++)
			unit_busy[u] = v;
	endfunction

	// Chooses a free run for the current mode; returns -1 when none fits.
	function automatic int choose_run(int size);
		int u, s, len, origin, pick, pick_len, after, before_run, last;
		bit found;
		u = 0;
		origin = 0;
		pick = -1;
		pick_len = 0;
		after = -1;
		before_run = -1;
		found = 1'b0;
		if (q_fill != 0) begin
			last = (q_tail + UNITS - 1) % UNITS;
			origin = fifo_start[last] + fifo_len[last];
			if (origin >= UNITS)
				origin = 0;
		end
		while (u < UNITS) begin
			if (unit_busy[u]) begin
				u++;
				continue;
			end
			s = u;
			while (u < UNITS && !unit_busy[u])
				u++;
			len = u - s;
			case (cur_mode)
				MODE_FIRST: begin
					if (!found && len >= size) begin
						found = 1'b1;
						pick = s;
					end
				end
				MODE_NEXT: begin
					if (len >= size) begin
						if (s >= origin && after < 0)
							after = s;
						if (s < origin && before_run < 0)
							before_run = s;
					end
				end
				MODE_BEST: begin
					if (len >= size && (!found || len < pick_len)) begin
						found = 1'b1;
						pick = s;
						pick_len = len;
					end
				end
				default: begin
					if (len > pick_len) begin
						pick = s;
						pick_len = len;
					end
				end
			endcase
		end
		if (cur_mode == MODE_NEXT)
			return (after >= 0) ? after : before_run;
		if (cur_mode == MODE_WORST)
			return (pick_len >= size && pick_len > 0) ? pick : -1;
		return found ? pick : -1;
	endfunction

	// Applies one accepted request to the mirror and returns the reply it causes.
	function automatic res_t place_request(req_t r);
		res_t o;
		int where, holes, used;
		o = '0;
		o.status = STAT_REJECT;
		if (r.proc_size != 0 && r.proc_size <= UNITS) begin
			where = choose_run(r.proc_size);
			if (where >= 0) begin
				if (q_fill < UNITS) begin
					mark_run(where, r.proc_size, 1'b1);
					fifo_id[q_tail] = r.proc_id;
					fifo_start[q_tail] = where;
					fifo_len[q_tail] = r.proc_size;
					fifo_swaps[q_tail] = r.swap_count;
					q_tail = (q_tail + 1) % UNITS;
					q_fill++;
					o.status = STAT_PLACED;
					o.start_unit = where[6:0];
				end
			end else if (q_fill > 0) begin
				mark_run(fifo_start[q_head], fifo_len[q_head], 1'b0);
				o.evicted_id = fifo_id[q_head];
				o.evicted_swaps = (fifo_swaps[q_head] == SWAP_MAX) ? SWAP_MAX
					: fifo_swaps[q_head] + 3'd1;
				o.evicted_requeue = (o.evicted_swaps < cur_limit);
				q_head = (q_head + 1) % UNITS;
				q_fill--;
				o.status = STAT_EVICTED;
			end
		end
		holes = 0;
		used = 0;
		for (int u = 0; u < UNITS; u++) begin
			if (unit_busy[u])
				used++;
			else if (u == 0 || unit_busy[u-1])
				holes++;
		end
		o.resident_count = q_fill[7:0];
		o.hole_count = holes[6:0];
		o.used_units = used[7:0];
		return o;
	endfunction

	// Sends one request beat; start stays high afterwards so that a following
	// beat of the same burst needs no second assignment in one time step.
	task automatic send_request(input req_t r, output res_t reply);
		bit taken;
		req <= r;
		start <= 1'b1;
		do begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end while (!taken);
		reply = place_request(r);
		expected_replies.push_back(reply);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Sends a request, spacing beats in bursts with random gaps, and
	// resubmits after each eviction the way a host would.
	task automatic submit(input req_t r);
		res_t reply;
		do begin
			if (burst_left == 0) begin
				idle_cycles($urandom_range(0, 1) ? $urandom_range(1, 300) : 1);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
			send_request(r, reply);
			if (reply.status == STAT_EVICTED && reply.evicted_requeue)
				requeue_list.push_back('{reply.evicted_id, 8'($urandom_range(1, 40)),
					reply.evicted_swaps});
		end while (reply.status == STAT_EVICTED);
	endtask

	// Waits until every predicted reply has come back and the block is idle.
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (expected_replies.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [2:0] val);
		bit taken;
		drain();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
			taken = cfg_ready;
			@(negedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		if (idx == REG_FIT_MODE)
			cur_mode = val[1:0];
		else
			cur_limit = val;
	endtask

	function automatic req_t make_req(int id, int size, int swaps);
		return '{8'(id), 8'(size), 3'(swaps)};
	endfunction

	// Boundary sizes, a full map, eviction with saturation and requeue.
	task automatic test_edges;
		write_reg(REG_SWAP_LIMIT, 3'd7);
		submit(make_req(1, 0, 0));
		submit(make_req(2, 129, 0));
		submit(make_req(255, 255, 6));
		submit(make_req(3, 128, 6));
		submit(make_req(4, 1, 0));
		submit(make_req(5, 127, 5));
		submit(make_req(6, 2, 1));
		write_reg(REG_SWAP_LIMIT, 3'd0);
		submit(make_req(7, 128, 0));
		submit(make_req(8, 64, 6));
		submit(make_req(9, 80, 0));
	endtask

	// A fragmented layout that tells the four modes apart, tried in each.
	task automatic test_modes;
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_FIT_MODE, 3'(m));
			write_reg(REG_SWAP_LIMIT, 3'd1);
			// Flush whatever is resident by forcing evictions.
			submit(make_req(10, 128, 0));
			submit(make_req(11, 128, 0));
			submit(make_req(12, 10, 0));
			submit(make_req(13, 5, 0));
			submit(make_req(12, 20, 0));
			submit(make_req(14, 3, 0));
			submit(make_req(15, 8, 2));
			submit(make_req(16, 4, 3));
		end
	endtask

	// Long random phases; most traffic is host-like with requeues.
	task automatic test_random;
		req_t r;
		for (int phase = 0; phase < 8; phase++) begin
			write_reg(REG_FIT_MODE, 3'($urandom_range(0, 3)));
			write_reg(REG_SWAP_LIMIT, 3'($urandom_range(0, 7)));
			for (int n = 0; n < 60; n++) begin
				if (requeue_list.size() != 0 && $urandom_range(0, 2) == 0)
					r = requeue_list.pop_front();
				else if ($urandom_range(0, 19) == 0)
					r = make_req($urandom_range(1, 255), $urandom_range(0, 255),
						$urandom_range(0, 6));
				else
					r = make_req($urandom_range(1, 255),
						$urandom_range(0, 7) == 0 ? $urandom_range(1, 128)
						: $urandom_range(1, 24), $urandom_range(0, 6));
				submit(r);
			end
		end
	endtask

	// Result beats cannot be held off, so every strobe is checked as it comes.
	always @(posedge clk) begin
		res_t e;
		if (arst_n && result_valid) begin
			if (expected_replies.size() == 0) begin
				$error("result beat with no request outstanding");
				failed = 1'b1;
			end else begin
				e = expected_replies.pop_front();
				if (res.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, res.status);
					failed = 1'b1;
				end
				if (res.start_unit !== e.start_unit) begin
					$error("start_unit expected %0d actual %0d", e.start_unit,
						res.start_unit);
					failed = 1'b1;
				end
				if (res.evicted_id !== e.evicted_id) begin
					$error("evicted_id expected %0d actual %0d", e.evicted_id,
						res.evicted_id);
					failed = 1'b1;
				end
				if (res.evicted_swaps !== e.evicted_swaps) begin
					$error("evicted_swaps expected %0d actual %0d", e.evicted_swaps,
						res.evicted_swaps);
					failed = 1'b1;
				end
				if (res.evicted_requeue !== e.evicted_requeue) begin
					$error("evicted_requeue expected %0d actual %0d", e.evicted_requeue,
						res.evicted_requeue);
					failed = 1'b1;
				end
				if (res.resident_count !== e.resident_count) begin
					$error("resident_count expected %0d actual %0d", e.resident_count,
						res.resident_count);
					failed = 1'b1;
				end
				if (res.hole_count !== e.hole_count) begin
					$error("hole_count expected %0d actual %0d", e.hole_count,
						res.hole_count);
					failed = 1'b1;
				end
				if (res.used_units !== e.used_units) begin
					$error("used_units expected %0d actual %0d", e.used_units,
						res.used_units);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		failed = 1'b0;
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int u = 0; u < UNITS; u++)
			unit_busy[u] = 1'b0;
		q_head = 0;
		q_tail = 0;
		q_fill = 0;
		cur_mode = FIT_MODE_RST;
		cur_limit = SWAP_LIMIT_RST;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		// First beats run with the reset register values.
		submit(make_req(20, 16, 0));
		submit(make_req(21, 128, 2));
		test_edges();
		test_modes();
		test_random();
		drain();
		repeat (300) @(negedge clk);
		if (!failed && expected_replies.size() == 0)
			$display("PASS contiguous_fit_allocator");
		else
			$display("FAIL contiguous_fit_allocator");
		$finish;
	end

	initial begin
		#50ms;
		$display("FAIL contiguous_fit_allocator");
		$finish;
	end

endmodule
`default_nettype wire
